[design/slrd_pkg.sv]
// slrd_pkg: shared constants, codes and item types of the serial link
// receive dispatcher; no dependencies
package slrd_pkg;

  // queue geometry
  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned NUM_QUEUES  = 4;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QIDX_W      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned MEM_DEPTH   = NUM_QUEUES * QUEUE_DEPTH;
  localparam int unsigned ADDR_W      = $clog2(MEM_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // item field widths
  localparam int unsigned WORD_W    = 24;
  localparam int unsigned CARD_W    = 3;
  localparam int unsigned CHAN_W    = 7;
  localparam int unsigned SEQ_W     = 8;
  localparam int unsigned CNT_OUT_W = 7;

  // link channels with a dedicated meaning
  localparam logic [CHAN_W-1:0] CHAN_IRQ   = 7'd0;
  localparam logic [CHAN_W-1:0] CHAN_REPLY = 7'd3;

  typedef enum logic [2:0] {
    OP_RX_WORD    = 3'd0,
    OP_STATUS     = 3'd1,
    OP_READ_START = 3'd2,
    OP_SEQ_START  = 3'd3,
    OP_DEQUEUE    = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_IRQ      = 3'd1,
    EV_REPLY    = 3'd2,
    EV_QUEUED   = 3'd3,
    EV_LOST     = 3'd4,
    EV_DEQUEUED = 3'd5,
    EV_REFUSED  = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    RD_DONE     = 2'd0,
    RD_ACTIVE   = 2'd1,
    RD_PARERR   = 2'd2,
    RD_OVERFLOW = 2'd3
  } read_state_e;

  typedef enum logic [2:0] {
    SQ_DONE    = 3'd0,
    SQ_ACTIVE  = 3'd1,
    SQ_ABORTED = 3'd2,
    SQ_PARERR  = 3'd3,
    SQ_BUSERR  = 3'd4
  } seq_state_e;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [WORD_W-1:0] rx_word;
    logic [CARD_W-1:0] card;
    logic              seq_complete;
    logic              seq_aborted;
    logic              parity_error;
    logic              bus_error;
    logic              rx_overflow;
    logic [SEQ_W-1:0]  seq_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           event_code;
    logic [WORD_W-1:0]    word_out;
    logic [1:0]           read_state;
    logic [2:0]           seq_state;
    logic                 seq_changed;
    logic [SEQ_W-1:0]     seq_count;
    logic [CNT_OUT_W-1:0] queue_count;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } ctrl_cmd_t;

endpackage

[design/slrd_if.sv]
// slrd_if: valid/ready channel interfaces for input and result transactions
// depends on slrd_pkg
interface slrd_in_if;
  logic                valid;
  logic                ready;
  slrd_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface slrd_out_if;
  logic                valid;
  logic                ready;
  slrd_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/slrd_ctrl.sv]
// slrd_ctrl: one-hot sequencer that steps each transaction through capture,
// execute and output load; depends on slrd_pkg
module slrd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output slrd_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_LOAD = 3'b100
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  // output register can take a new result
  assign slot_free = !out_valid_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_LOAD;
      end
      ST_LOAD: begin
        if (slot_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // an accepted transaction always goes to execute next
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_EXEC))
    else $error("accepted transaction did not enter execute");

  // a load always presents a result on the next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> out_valid_q)
    else $error("loaded result not marked valid");

endmodule

[design/slrd_dpath.sv]
// slrd_dpath: input register, per-card ring queues in one memory, link
// status registers and result registers; depends on slrd_pkg
module slrd_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slrd_pkg::ctrl_cmd_t cmd_i,
  input  slrd_pkg::in_item_t  item_i,
  output slrd_pkg::out_item_t result_o
);

  localparam int unsigned PTR_W  = slrd_pkg::PTR_W;
  localparam int unsigned QIDX_W = slrd_pkg::QIDX_W;
  localparam int unsigned ADDR_W = slrd_pkg::ADDR_W;
  localparam int unsigned CNT_W  = slrd_pkg::CNT_W;
  localparam int unsigned WORD_W = slrd_pkg::WORD_W;
  localparam int unsigned NQ     = slrd_pkg::NUM_QUEUES;

  slrd_pkg::in_item_t    in_q;
  slrd_pkg::out_item_t   res_q, res_d, out_q;
  logic                  deq_q;

  // queue pointers and flags
  logic [PTR_W-1:0]      head_q [NQ];
  logic [PTR_W-1:0]      tail_q [NQ];
  logic                  full_q [NQ];

  // link status
  slrd_pkg::read_state_e rd_q, rd_d;
  slrd_pkg::seq_state_e  sq_q, sq_d;
  logic [slrd_pkg::SEQ_W-1:0] words_q, words_d;

  // queue memory
  logic [WORD_W-1:0]     mem [slrd_pkg::MEM_DEPTH];
  logic [WORD_W-1:0]     rdata_q;

  logic [QIDX_W-1:0]     qidx;
  logic                  in_range;
  logic [PTR_W-1:0]      cur_head, cur_tail, head_n, tail_n;
  logic                  cur_full, full_n;
  logic                  mem_we, mem_re, deq_d;
  logic [ADDR_W-1:0]     wr_addr, rd_addr;
  logic [CNT_W-1:0]      held;
  logic [slrd_pkg::CHAN_W-1:0] chan;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(slrd_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  // input register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= item_i;
    end
  end

  // addressed queue
  assign qidx     = in_q.card[QIDX_W-1:0];
  assign in_range = {1'b0, in_q.card} < (slrd_pkg::CARD_W + 1)'(NQ);
  assign cur_head = head_q[qidx];
  assign cur_tail = tail_q[qidx];
  assign cur_full = full_q[qidx];
  assign chan     = in_q.rx_word[22:16];

  // transaction decode and state update
  always_comb begin
    rd_d    = rd_q;
    sq_d    = sq_q;
    words_d = words_q;
    head_n  = cur_head;
    tail_n  = cur_tail;
    full_n  = cur_full;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    deq_d   = 1'b0;
    res_d   = '0;
    res_d.event_code = slrd_pkg::EV_NONE;
    unique case (in_q.opcode)
      slrd_pkg::OP_RX_WORD: begin
        if (chan == slrd_pkg::CHAN_IRQ) begin
          res_d.event_code = slrd_pkg::EV_IRQ;
          res_d.word_out   = in_q.rx_word;
        end else if (chan == slrd_pkg::CHAN_REPLY && rd_q == slrd_pkg::RD_ACTIVE) begin
          rd_d             = slrd_pkg::RD_DONE;
          res_d.event_code = slrd_pkg::EV_REPLY;
          res_d.word_out   = in_q.rx_word;
        end else if (in_range && !cur_full) begin
          mem_we           = 1'b1;
          tail_n           = next_slot(cur_tail);
          full_n           = (tail_n == cur_head);
          res_d.event_code = slrd_pkg::EV_QUEUED;
        end else begin
          res_d.event_code = slrd_pkg::EV_LOST;
        end
      end
      slrd_pkg::OP_STATUS: begin
        // complete wins over abort; parity moves only active states; bus error overrides them all; overflow last
        if (in_q.seq_complete) begin
          sq_d              = slrd_pkg::SQ_DONE;
          res_d.seq_changed = 1'b1;
        end else if (in_q.seq_aborted) begin
          sq_d              = slrd_pkg::SQ_ABORTED;
          words_d           = in_q.seq_index;
          res_d.seq_changed = 1'b1;
        end
        if (in_q.parity_error) begin
          if (sq_d == slrd_pkg::SQ_ACTIVE) begin
            sq_d              = slrd_pkg::SQ_PARERR;
            res_d.seq_changed = 1'b1;
          end
          if (rd_d == slrd_pkg::RD_ACTIVE) begin
            rd_d = slrd_pkg::RD_PARERR;
          end
        end
        if (in_q.bus_error) begin
          sq_d              = slrd_pkg::SQ_BUSERR;
          words_d           = in_q.seq_index;
          res_d.seq_changed = 1'b1;
        end
        if (in_q.rx_overflow && rd_d == slrd_pkg::RD_ACTIVE) begin
          rd_d = slrd_pkg::RD_OVERFLOW;
        end
      end
      slrd_pkg::OP_READ_START: begin
        rd_d = slrd_pkg::RD_ACTIVE;
      end
      slrd_pkg::OP_SEQ_START: begin
        if (sq_q == slrd_pkg::SQ_ACTIVE || sq_q == slrd_pkg::SQ_PARERR) begin
          res_d.event_code = slrd_pkg::EV_REFUSED;
        end else begin
          sq_d = slrd_pkg::SQ_ACTIVE;
        end
      end
      slrd_pkg::OP_DEQUEUE: begin
        if (in_range && (cur_full || cur_head != cur_tail)) begin
          mem_re           = 1'b1;
          deq_d            = 1'b1;
          head_n           = next_slot(cur_head);
          full_n           = 1'b0;
          res_d.event_code = slrd_pkg::EV_DEQUEUED;
        end else begin
          res_d.event_code = slrd_pkg::EV_REFUSED;
        end
      end
      default: begin
      end
    endcase

    res_d.read_state = rd_d;
    res_d.seq_state  = sq_d;
    if (sq_d == slrd_pkg::SQ_ABORTED || sq_d == slrd_pkg::SQ_BUSERR) begin
      res_d.seq_count = words_d;
    end
    res_d.queue_count = in_range ? slrd_pkg::CNT_OUT_W'(held) : '0;
  end

  // fill level after this transaction
  always_comb begin
    if (full_n) begin
      held = CNT_W'(slrd_pkg::QUEUE_DEPTH);
    end else if (tail_n >= head_n) begin
      held = CNT_W'(tail_n) - CNT_W'(head_n);
    end else begin
      held = CNT_W'(slrd_pkg::QUEUE_DEPTH) - CNT_W'(head_n) + CNT_W'(tail_n);
    end
  end

  // memory addresses: card base plus slot
  assign wr_addr = ADDR_W'(qidx) * ADDR_W'(slrd_pkg::QUEUE_DEPTH) + ADDR_W'(cur_tail);
  assign rd_addr = ADDR_W'(qidx) * ADDR_W'(slrd_pkg::QUEUE_DEPTH) + ADDR_W'(cur_head);

  // queue memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && mem_we) begin
      mem[wr_addr] <= in_q.rx_word;
    end
    if (cmd_i.exec && mem_re) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // status and pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q    <= slrd_pkg::RD_DONE;
      sq_q    <= slrd_pkg::SQ_DONE;
      words_q <= '0;
      for (int i = 0; i < NQ; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        full_q[i] <= 1'b0;
      end
    end else if (cmd_i.exec) begin
      rd_q    <= rd_d;
      sq_q    <= sq_d;
      words_q <= words_d;
      if (in_range) begin
        head_q[qidx] <= head_n;
        tail_q[qidx] <= tail_n;
        full_q[qidx] <= full_n;
      end
    end
  end

  // result staging and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_q <= res_d;
      deq_q <= deq_d;
    end
    if (cmd_i.load) begin
      out_q <= res_q;
      if (deq_q) begin
        out_q.word_out <= rdata_q;
      end
    end
  end

  assign result_o = out_q;

  // a full queue has its pointers meeting
  a_full_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && in_range && cur_full) |-> (cur_head == cur_tail))
    else $error("queue marked full with head and tail apart");

  // a read start always leaves the read active
  a_read_arm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && in_q.opcode == slrd_pkg::OP_READ_START) |=>
      (rd_q == slrd_pkg::RD_ACTIVE))
    else $error("read start did not arm the read");

endmodule

[design/serial_link_receive_dispatcher_top.sv]
// serial_link_receive_dispatcher_top: joins the sequencer and the datapath
// behind the input and result channels; depends on slrd_pkg, slrd_if,
// slrd_ctrl and slrd_dpath
// flow: an accepted input is captured, executed and loaded into the result
//   register by the sequencer around the queue memory read port, and a new
//   input is taken only after the load; the load waits while a finished
//   result sits unaccepted on the output register
// reset: asynchronous active low; clears link states, queue pointers and
//   flags at once; queue memory contents are not cleared
module serial_link_receive_dispatcher_top (
  input  logic clk_i,
  input  logic rst_ni,
  slrd_in_if.sink    item_i,
  slrd_out_if.source result_o
);

  slrd_pkg::ctrl_cmd_t cmd;

  slrd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd)
  );

  slrd_dpath u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item_i.data),
    .result_o (result_o.data)
  );

endmodule
